// ===== rtl/sdcs_pkg.sv =====
// Shared constants, types and register codes for the static defect cell suppressor.
`default_nettype none

package sdcs_pkg;

  localparam int unsigned MAX_REPORTS  = 64;
  localparam int unsigned CELL_ENTRIES = 64;
  localparam int unsigned CAMERAS      = 4;   // power of two: camera index wraps by bit select

  localparam int unsigned RPT_AW  = $clog2(MAX_REPORTS);
  localparam int unsigned RPT_CW  = $clog2(MAX_REPORTS + 1);
  localparam int unsigned CE_W    = $clog2(CELL_ENTRIES);
  localparam int unsigned CE_CW   = $clog2(CELL_ENTRIES + 1);
  localparam int unsigned CAM_W   = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int unsigned TBL_AW  = CAM_W + CE_W;
  localparam int unsigned TBL_D   = CAMERAS * CELL_ENTRIES;

  localparam int unsigned CRD_W   = 12;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned FTOT_W  = 32;

  localparam int unsigned IN_DW   = 64;   // camera, pos_x, pos_y, defect_tag
  localparam int unsigned OUT_DW  = 56;   // out_x, out_y, out_tag
  localparam int unsigned OUT_UW  = 3;    // heartbeat, none_kept, overflow
  localparam int unsigned CFG_IW  = 8;
  localparam int unsigned CFG_DW  = 16;

  // remainder unit widths
  localparam int unsigned REM_DW  = 32;
  localparam int unsigned REM_SW  = 16;
  localparam int unsigned REM_CW  = $clog2(REM_DW + 1);

  localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [FTOT_W-1:0] EARLY_FRAMES = 32'd5;

  localparam logic [CFG_IW-1:0] REG_MIN_STREAK = 8'd0;
  localparam logic [CFG_IW-1:0] REG_CELL_SIZE  = 8'd1;
  localparam logic [CFG_IW-1:0] REG_COOLDOWN   = 8'd2;
  localparam logic [CFG_IW-1:0] REG_HB_IVAL    = 8'd3;

  localparam logic [0:0] KIND_REPORT    = 1'b0;
  localparam logic [0:0] KIND_FRAME_END = 1'b1;

  typedef struct packed {
    logic [CE_W-1:0]  slot;
    logic             track;
    logic [CRD_W-1:0] qy;
    logic [CRD_W-1:0] qx;
    logic [TAG_W-1:0] tag;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] x;
  } rep_t;

  typedef struct packed {
    logic             supp;
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    logic [CNT_W-1:0] streak;
    logic [CNT_W-1:0] absent;
  } cell_t;

  typedef struct packed {
    logic             hb;
    logic             none;
    logic [TAG_W-1:0] tag;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] x;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sdcs_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sdcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/sdcs_rem.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module sdcs_rem (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [sdcs_pkg::REM_DW-1:0]  dividend_i,
  input  wire logic [sdcs_pkg::REM_SW-1:0]  divisor_i,
  output      logic                         done_o,
  output      logic [sdcs_pkg::REM_SW-1:0]  rem_o
);
  import sdcs_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [REM_CW-1:0] cnt_q;
  logic [REM_DW-1:0] dvd_q;
  logic [REM_SW-1:0] dvs_q;
  logic [REM_SW-1:0] r_q;
  logic [REM_SW:0]   trial;
  logic [REM_SW-1:0] r_d;

  always_comb begin
    trial = {r_q, dvd_q[REM_DW-1]};
    if (trial >= {1'b0, dvs_q}) begin
      r_d = REM_SW'(trial - {1'b0, dvs_q});
    end else begin
      r_d = trial[REM_SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= REM_CW'(REM_DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == REM_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      r_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[REM_DW-2:0], 1'b0};
      r_q   <= r_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

// ===== rtl/static_defect_cell_suppressor.sv =====
// Static defect cell suppressor: report buffer, per-camera cell table and frame sequencer.
// Usage:
//  Reports (tuser kind 0) stream in on s_axis and are buffered, one per cycle,
//  up to 64 per frame; extra reports are dropped and flag overflow. A frame-end
//  item (kind 1, camera in tdata) closes the frame: reports are quantized to grid
//  cells, the camera's cell table is refreshed and aged, new cells are inserted,
//  and the reports of unsuppressed cells leave on m_axis in arrival order, tlast
//  on the final one. A frame always yields at least one result (a heartbeat copy
//  or a none_kept marker).
//  A frame end quantizes every report to its cell (two remainder runs each),
//  scans the camera's table twice through the single table read port, runs
//  an aging pass over the table and then emits the results; this work is
//  bounded by the table RAM read port and the shared remainder unit.
//  s_axis is not ready while a frame end is in work; it reopens as soon as the
//  final result sits in the output register. A stalled receiver holds the
//  output register and stalls emission. After reset every table entry is
//  invalid through per-entry valid flops; no clearing pass is needed.
//  Config writes (cfg_*) are always ready and must only occur while idle.
`default_nettype none

module static_defect_cell_suppressor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // camera[1:0], pos_x[13:2], pos_y[25:14], defect_tag[57:26]
  input  wire logic [sdcs_pkg::IN_DW-1:0]    s_axis_tdata,
  // kind[0]
  input  wire logic                          s_axis_tuser,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // out_x[11:0], out_y[23:12], out_tag[55:24]
  output      logic [sdcs_pkg::OUT_DW-1:0]   m_axis_tdata,
  // heartbeat[0], none_kept[1], overflow[2]
  output      logic [sdcs_pkg::OUT_UW-1:0]   m_axis_tuser,
  output      logic                          m_axis_tlast,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [sdcs_pkg::CFG_IW-1:0]   cfg_index_i,
  input  wire logic [sdcs_pkg::CFG_DW-1:0]   cfg_data_i
);
  import sdcs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_QRD    = 4'd1;
  localparam logic [3:0] S_QLAT   = 4'd2;
  localparam logic [3:0] S_QX     = 4'd3;
  localparam logic [3:0] S_QY     = 4'd4;
  localparam logic [3:0] S_SRD    = 4'd5;
  localparam logic [3:0] S_SLAT   = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_AGE_RD = 4'd8;
  localparam logic [3:0] S_AGE_WB = 4'd9;
  localparam logic [3:0] S_DRD    = 4'd10;
  localparam logic [3:0] S_DTB    = 4'd11;
  localparam logic [3:0] S_DCHK   = 4'd12;
  localparam logic [3:0] S_HB     = 4'd13;
  localparam logic [3:0] S_HBW    = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  // config
  logic [CNT_W-1:0] min_streak_q, cooldown_q, hb_ival_q;
  logic [12:0]      cell_size_q;

  logic [3:0]       state_q, state_d;
  logic [RPT_CW-1:0] cnt_q, idx_q;
  logic             bovf_q, ovf_q;
  logic [CAM_W-1:0] cam_q;
  logic [FTOT_W-1:0] ftot_q [CAMERAS];
  logic [FTOT_W-1:0] total_q;
  logic [CAMERAS-1:0][CELL_ENTRIES-1:0] valid_q;
  logic [CELL_ENTRIES-1:0] present_q;
  logic             pass_c_q;
  logic [CE_W-1:0]  sk_q, chk_k_q;
  logic             chk_v_q;
  logic [CE_CW-1:0] k_q;
  rep_t             rep_q;
  res_t             first_q, pend_q;
  logic             pend_v_q;
  res_t             out_q;
  logic             out_v_q, out_ovf_q, out_last_q;

  // input fields
  logic             in_kind;
  logic [CAM_W-1:0] in_cam;
  logic [CRD_W-1:0] in_x, in_y;
  logic [TAG_W-1:0] in_tag;
  logic             in_acc;

  assign in_kind = s_axis_tuser;
  assign in_cam  = s_axis_tdata[CAM_W-1:0];
  assign in_x    = s_axis_tdata[13:2];
  assign in_y    = s_axis_tdata[25:14];
  assign in_tag  = s_axis_tdata[57:26];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // RAM ports
  logic              rep_we;
  logic [RPT_AW-1:0] rep_waddr;
  rep_t              rep_wdata, rep_rdata;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  cell_t             tbl_wdata, tbl_rdata;

  sdcs_ram #(.WIDTH($bits(rep_t)), .DEPTH(MAX_REPORTS)) u_rep_ram (
    .clk_i   (clk_i),
    .we_i    (rep_we),
    .waddr_i (rep_waddr),
    .wdata_i (rep_wdata),
    .raddr_i (idx_q[RPT_AW-1:0]),
    .rdata_o (rep_rdata)
  );

  sdcs_ram #(.WIDTH($bits(cell_t)), .DEPTH(TBL_D)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // remainder unit
  logic              rem_start, rem_done;
  logic [REM_DW-1:0] rem_dvd;
  logic [REM_SW-1:0] rem_dvs, rem_val;
  logic [REM_SW-1:0] cs_eff;

  assign cs_eff = (cell_size_q == '0) ? REM_SW'(1) : REM_SW'(cell_size_q);

  sdcs_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (rem_dvs),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_comb begin
    rem_start = 1'b0;
    rem_dvd   = REM_DW'(rep_rdata.x);
    rem_dvs   = cs_eff;
    case (state_q)
      S_QLAT: begin
        rem_start = 1'b1;
        rem_dvd   = REM_DW'(rep_rdata.x);
      end
      S_QX: begin
        rem_start = rem_done;
        rem_dvd   = REM_DW'(rep_q.y);
      end
      S_HB: begin
        rem_start = !pend_v_q && (cnt_q != '0) && (hb_ival_q != '0);
        rem_dvd   = total_q;
        rem_dvs   = hb_ival_q;
      end
      default: ;
    endcase
  end

  // scan compare: table data belongs to entry chk_k_q
  logic sc_hit, sc_miss;
  logic [CELL_ENTRIES-1:0] row_valid;
  logic             free_any;
  logic [CE_W-1:0]  free_idx;

  assign row_valid = valid_q[cam_q];
  assign sc_hit  = chk_v_q && row_valid[chk_k_q] &&
                   (tbl_rdata.cx == rep_q.qx) && (tbl_rdata.cy == rep_q.qy);
  assign sc_miss = chk_v_q && !sc_hit && (chk_k_q == CE_W'(CELL_ENTRIES - 1));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int j = CELL_ENTRIES - 1; j >= 0; j--) begin
      if (!row_valid[j]) begin
        free_any = 1'b1;
        free_idx = CE_W'(j);
      end
    end
  end

  // aging of one entry
  cell_t aged;
  logic  keep;
  logic [CE_W-1:0] k_idx;

  assign k_idx = k_q[CE_W-1:0];

  always_comb begin
    aged = tbl_rdata;
    keep = 1'b1;
    if (present_q[k_idx]) begin
      if (tbl_rdata.streak != COUNT_MAX) begin
        aged.streak = tbl_rdata.streak + 1'b1;
      end
      aged.absent = '0;
    end else begin
      if (tbl_rdata.absent != COUNT_MAX) begin
        aged.absent = tbl_rdata.absent + 1'b1;
      end
      keep = (aged.absent <= cooldown_q);
    end
    aged.supp = tbl_rdata.supp || (aged.streak >= min_streak_q);
  end

  cell_t new_cell;
  always_comb begin
    new_cell.supp   = (CNT_W'(1) >= min_streak_q);
    new_cell.cx     = rep_q.qx;
    new_cell.cy     = rep_q.qy;
    new_cell.streak = CNT_W'(1);
    new_cell.absent = '0;
  end

  logic out_free, d_supp;
  assign out_free = !out_v_q || m_axis_tready;
  assign d_supp   = rep_q.track && tbl_rdata.supp;

  // RAM write and read muxing
  always_comb begin
    rep_we    = 1'b0;
    rep_waddr = idx_q[RPT_AW-1:0];
    rep_wdata = rep_q;
    tbl_we    = 1'b0;
    tbl_waddr = {cam_q, k_idx};
    tbl_wdata = aged;
    tbl_raddr = {cam_q, sk_q};
    case (state_q)
      S_IDLE: begin
        rep_we          = in_acc && (in_kind == KIND_REPORT) &&
                          (cnt_q < RPT_CW'(MAX_REPORTS));
        rep_waddr       = cnt_q[RPT_AW-1:0];
        rep_wdata       = '0;
        rep_wdata.x     = in_x;
        rep_wdata.y     = in_y;
        rep_wdata.tag   = in_tag;
      end
      S_QY: begin
        rep_we          = rem_done;
        rep_wdata.qy    = rep_q.y - rem_val[CRD_W-1:0];
        rep_wdata.track = 1'b0;
        rep_wdata.slot  = '0;
      end
      S_SCAN: begin
        if (sc_hit) begin
          rep_we          = 1'b1;
          rep_wdata.track = 1'b1;
          rep_wdata.slot  = chk_k_q;
        end else if (sc_miss && pass_c_q && free_any) begin
          rep_we          = 1'b1;
          rep_wdata.track = 1'b1;
          rep_wdata.slot  = free_idx;
          tbl_we          = 1'b1;
          tbl_waddr       = {cam_q, free_idx};
          tbl_wdata       = new_cell;
        end
      end
      S_AGE_RD: tbl_raddr = {cam_q, k_idx};
      S_AGE_WB: tbl_we    = 1'b1;
      S_DTB:    tbl_raddr = {cam_q, rep_rdata.slot};
      // keep the entry on the read port while emission waits
      S_DCHK:   tbl_raddr = {cam_q, rep_q.slot};
      default: ;
    endcase
  end

  // sequencer
  logic idx_end;
  assign idx_end = (idx_q == cnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc && in_kind == KIND_FRAME_END) state_d = S_QRD;
      S_QRD:    state_d = idx_end ? S_SRD : S_QLAT;
      S_QLAT:   state_d = S_QX;
      S_QX:     if (rem_done) state_d = S_QY;
      S_QY:     if (rem_done) state_d = S_QRD;
      S_SRD: begin
        if (!idx_end) begin
          state_d = S_SLAT;
        end else begin
          state_d = pass_c_q ? S_DRD : S_AGE_RD;
        end
      end
      S_SLAT:   state_d = (pass_c_q && rep_rdata.track) ? S_SRD : S_SCAN;
      S_SCAN:   if (sc_hit || sc_miss) state_d = S_SRD;
      S_AGE_RD: begin
        if (k_q == CE_CW'(CELL_ENTRIES)) begin
          state_d = S_SRD;
        end else if (row_valid[k_idx]) begin
          state_d = S_AGE_WB;
        end
      end
      S_AGE_WB: state_d = S_AGE_RD;
      S_DRD:    state_d = idx_end ? S_HB : S_DTB;
      S_DTB:    state_d = S_DCHK;
      S_DCHK:   if (d_supp || !pend_v_q || out_free) state_d = S_DRD;
      S_HB:     state_d = rem_start ? S_HBW : S_FIN;
      S_HBW:    if (rem_done) state_d = S_FIN;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  res_t none_res;
  always_comb begin
    none_res      = '0;
    none_res.none = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      min_streak_q <= CNT_W'(5);
      cell_size_q  <= 13'd32;
      cooldown_q   <= CNT_W'(10);
      hb_ival_q    <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      bovf_q       <= 1'b0;
      ovf_q        <= 1'b0;
      cam_q        <= '0;
      total_q      <= '0;
      valid_q      <= '0;
      present_q    <= '0;
      pass_c_q     <= 1'b0;
      sk_q         <= '0;
      chk_k_q      <= '0;
      chk_v_q      <= 1'b0;
      k_q          <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
      for (int c = 0; c < CAMERAS; c++) begin
        ftot_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MIN_STREAK: min_streak_q <= cfg_data_i;
          REG_CELL_SIZE:  cell_size_q  <= cfg_data_i[12:0];
          REG_COOLDOWN:   cooldown_q   <= cfg_data_i;
          REG_HB_IVAL:    hb_ival_q    <= cfg_data_i;
          default: ;
        endcase
      end

      if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_kind == KIND_REPORT) begin
              if (cnt_q < RPT_CW'(MAX_REPORTS)) begin
                cnt_q <= cnt_q + 1'b1;
              end else begin
                bovf_q <= 1'b1;
              end
            end else begin
              cam_q          <= in_cam;
              ftot_q[in_cam] <= ftot_q[in_cam] + 1'b1;
              total_q        <= ftot_q[in_cam] + 1'b1;
              idx_q          <= '0;
              present_q      <= '0;
              ovf_q          <= bovf_q;
              pend_v_q       <= 1'b0;
              pass_c_q       <= 1'b0;
            end
          end
        end
        S_QRD: if (idx_end) idx_q <= '0;
        S_QY:  if (rem_done) idx_q <= idx_q + 1'b1;
        S_SRD: begin
          if (idx_end) begin
            idx_q <= '0;
            k_q   <= '0;
          end
        end
        S_SLAT: begin
          sk_q    <= '0;
          chk_v_q <= 1'b0;
          if (pass_c_q && rep_rdata.track) idx_q <= idx_q + 1'b1;
        end
        S_SCAN: begin
          if (sc_hit || sc_miss) begin
            idx_q   <= idx_q + 1'b1;
            chk_v_q <= 1'b0;
            if (sc_hit && !pass_c_q) begin
              present_q[chk_k_q] <= 1'b1;
            end
            if (sc_miss && pass_c_q) begin
              if (free_any) begin
                valid_q[cam_q][free_idx] <= 1'b1;
              end else begin
                ovf_q <= 1'b1;
              end
            end
          end else begin
            chk_k_q <= sk_q;
            chk_v_q <= 1'b1;
            sk_q    <= sk_q + 1'b1;
          end
        end
        S_AGE_RD: begin
          if (k_q == CE_CW'(CELL_ENTRIES)) begin
            pass_c_q <= 1'b1;
          end else if (!row_valid[k_idx]) begin
            k_q <= k_q + 1'b1;
          end
        end
        S_AGE_WB: begin
          valid_q[cam_q][k_idx] <= keep;
          k_q <= k_q + 1'b1;
        end
        S_DCHK: begin
          if (d_supp) begin
            idx_q <= idx_q + 1'b1;
          end else if (!pend_v_q || out_free) begin
            idx_q    <= idx_q + 1'b1;
            pend_v_q <= 1'b1;
            if (pend_v_q) out_v_q <= 1'b1;
          end
        end
        S_HB: begin
          if (!pend_v_q && !rem_start) pend_v_q <= 1'b1;
        end
        S_HBW: if (rem_done) pend_v_q <= 1'b1;
        S_FIN: begin
          if (out_free) begin
            out_v_q <= 1'b1;
            cnt_q   <= '0;
            bovf_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_QLAT: rep_q <= rep_rdata;
      S_QX:   if (rem_done) rep_q.qx <= rep_q.x - rem_val[CRD_W-1:0];
      S_SLAT: rep_q <= rep_rdata;
      S_DTB: begin
        rep_q <= rep_rdata;
        if (idx_q == '0) begin
          first_q.hb   <= 1'b1;
          first_q.none <= 1'b0;
          first_q.x    <= rep_rdata.x;
          first_q.y    <= rep_rdata.y;
          first_q.tag  <= rep_rdata.tag;
        end
      end
      S_DCHK: begin
        if (!d_supp && (!pend_v_q || out_free)) begin
          if (pend_v_q) begin
            out_q      <= pend_q;
            out_ovf_q  <= ovf_q;
            out_last_q <= 1'b0;
          end
          pend_q.hb   <= 1'b0;
          pend_q.none <= 1'b0;
          pend_q.x    <= rep_q.x;
          pend_q.y    <= rep_q.y;
          pend_q.tag  <= rep_q.tag;
        end
      end
      S_HB: if (!pend_v_q && !rem_start) pend_q <= none_res;
      S_HBW: begin
        if (rem_done) begin
          if (rem_val == '0 || total_q <= EARLY_FRAMES) begin
            pend_q <= first_q;
          end else begin
            pend_q <= none_res;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_q      <= pend_q;
          out_ovf_q  <= ovf_q;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.tag, out_q.y, out_q.x};
  assign m_axis_tuser  = {out_ovf_q, out_q.none, out_q.hb};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
